[hw/rtl/rpj_pkg.sv]
// Shared types, constants and fixed-point helpers of the reprojection Jacobian block.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package rpj_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QUAT_BITS = 30;
    localparam int QUO_BITS  = 33;
    localparam int DIV_LAT   = QUO_BITS + 2;
    localparam int FRONT_LAT = 5;
    localparam int NUM_LAT   = 1;
    localparam int BACK_LAT  = 2;
    localparam int PIPE_LAT  = FRONT_LAT + NUM_LAT + DIV_LAT + BACK_LAT;
    localparam int CFG_IDX_W = 3;
    localparam int REG_W     = 31;

    typedef logic signed [31:0] s32_t;
    typedef logic signed [63:0] s64_t;
    typedef s32_t [2:0] vec3_t;
    typedef s32_t [5:0] vec6_t;
    typedef s32_t [8:0] mat_t;

    localparam s32_t S32_MAX = 32'sh7FFFFFFF;
    localparam s32_t S32_MIN = 32'sh80000000;

    localparam logic [REG_W-1:0] FOCAL_X_RESET  = 31'd32768000;
    localparam logic [REG_W-1:0] FOCAL_Y_RESET  = 31'd32768000;
    localparam logic [REG_W-1:0] CENTER_X_RESET = 31'd20971520;
    localparam logic [REG_W-1:0] CENTER_Y_RESET = 31'd15728640;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X  = 3'd0,
        REG_FOCAL_Y  = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        s32_t focal_x;
        s32_t focal_y;
        s32_t center_x;
        s32_t center_y;
    } cfg_t;

    typedef struct packed {
        vec3_t point;
        s32_t  quat_w;
        s32_t  quat_x;
        s32_t  quat_y;
        s32_t  quat_z;
        vec3_t trans;
        s32_t  meas_u;
        s32_t  meas_v;
    } obs_t;

    typedef struct packed {
        mat_t  r;
        vec3_t cam;
        s32_t  meas_u;
        s32_t  meas_v;
    } cam_t;

    typedef struct packed {
        mat_t r;
        s32_t meas_u;
        s32_t meas_v;
        logic pos;
    } side_t;

    typedef struct packed {
        s32_t proj_u;
        s32_t proj_v;
        s32_t xz;
        s32_t yz;
        s32_t fxz;
        s32_t fyz;
    } quo_t;

    // Packed so that the residual lands in the lowest bits of the stream word.
    typedef struct packed {
        vec6_t dpose;
        vec3_t dpt;
        s32_t  residual;
    } row_t;

    typedef struct packed {
        row_t row_u;
        row_t row_v;
        logic pos;
    } rows_t;

    function automatic s32_t sat32(input s64_t v);
        s32_t r;
        if (v > 64'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < 64'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic s32_t neg_sat(input s32_t a);
        s32_t r;
        if (a == S32_MIN) begin
            r = S32_MAX;
        end else begin
            r = -a;
        end
        return r;
    endfunction

    // Round half toward plus infinity, then arithmetic shift.
    function automatic s64_t rnd_quat(input s64_t v);
        s64_t r;
        r = (v + (64'sd1 <<< (QUAT_BITS - 1))) >>> QUAT_BITS;
        return r;
    endfunction

    function automatic s32_t mulq(input s32_t a, input s32_t b);
        s64_t p;
        p = 64'(a) * 64'(b);
        return sat32((p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    endfunction

    function automatic s32_t qmul(input s32_t a, input s32_t b);
        s64_t p;
        p = rnd_quat(64'(a) * 64'(b));
        return p[31:0];
    endfunction

    function automatic s32_t clamp_unit(input logic signed [35:0] v);
        s32_t r;
        if (v > (36'sd1 <<< QUAT_BITS)) begin
            r = 32'sd1 <<< QUAT_BITS;
        end else if (v < -(36'sd1 <<< QUAT_BITS)) begin
            r = -(32'sd1 <<< QUAT_BITS);
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/rpj_front.sv]
// Front end: quaternion to rotation matrix and camera-frame point, five register stages.
// Depends on rpj_pkg.
`timescale 1ns / 1ps

module rpj_front (
    input  logic          aclk,
    input  logic          en,
    input  rpj_pkg::obs_t obs,
    output rpj_pkg::cam_t cam_out
);

    rpj_pkg::obs_t obs1_reg, obs2_reg, obs3_reg, obs4_reg;
    rpj_pkg::mat_t qp2_reg, r3_reg, r4_reg;
    rpj_pkg::s64_t [8:0] rp4_reg;

    rpj_pkg::obs_t obs1_next;
    rpj_pkg::mat_t qp2_next, r3_next;
    rpj_pkg::s64_t [8:0] rp4_next;
    rpj_pkg::cam_t cam_next;

    always_comb begin
        obs1_next = obs;
        obs1_next.quat_w = rpj_pkg::clamp_unit(36'(obs.quat_w));
        obs1_next.quat_x = rpj_pkg::clamp_unit(36'(obs.quat_x));
        obs1_next.quat_y = rpj_pkg::clamp_unit(36'(obs.quat_y));
        obs1_next.quat_z = rpj_pkg::clamp_unit(36'(obs.quat_z));
    end

    // Products in the order xx, yy, zz, xy, xz, yz, wx, wy, wz.
    always_comb begin
        qp2_next[0] = rpj_pkg::qmul(obs1_reg.quat_x, obs1_reg.quat_x);
        qp2_next[1] = rpj_pkg::qmul(obs1_reg.quat_y, obs1_reg.quat_y);
        qp2_next[2] = rpj_pkg::qmul(obs1_reg.quat_z, obs1_reg.quat_z);
        qp2_next[3] = rpj_pkg::qmul(obs1_reg.quat_x, obs1_reg.quat_y);
        qp2_next[4] = rpj_pkg::qmul(obs1_reg.quat_x, obs1_reg.quat_z);
        qp2_next[5] = rpj_pkg::qmul(obs1_reg.quat_y, obs1_reg.quat_z);
        qp2_next[6] = rpj_pkg::qmul(obs1_reg.quat_w, obs1_reg.quat_x);
        qp2_next[7] = rpj_pkg::qmul(obs1_reg.quat_w, obs1_reg.quat_y);
        qp2_next[8] = rpj_pkg::qmul(obs1_reg.quat_w, obs1_reg.quat_z);
    end

    always_comb begin
        logic signed [35:0] one;
        logic signed [35:0] xx, yy, zz, xy, xq, yq, wx, wy, wz;
        one = 36'sd1 <<< rpj_pkg::QUAT_BITS;
        xx = 36'(qp2_reg[0]);
        yy = 36'(qp2_reg[1]);
        zz = 36'(qp2_reg[2]);
        xy = 36'(qp2_reg[3]);
        xq = 36'(qp2_reg[4]);
        yq = 36'(qp2_reg[5]);
        wx = 36'(qp2_reg[6]);
        wy = 36'(qp2_reg[7]);
        wz = 36'(qp2_reg[8]);
        r3_next[0] = rpj_pkg::clamp_unit(one - 2 * (yy + zz));
        r3_next[1] = rpj_pkg::clamp_unit(2 * (xy - wz));
        r3_next[2] = rpj_pkg::clamp_unit(2 * (xq + wy));
        r3_next[3] = rpj_pkg::clamp_unit(2 * (xy + wz));
        r3_next[4] = rpj_pkg::clamp_unit(one - 2 * (xx + zz));
        r3_next[5] = rpj_pkg::clamp_unit(2 * (yq - wx));
        r3_next[6] = rpj_pkg::clamp_unit(2 * (xq - wy));
        r3_next[7] = rpj_pkg::clamp_unit(2 * (yq + wx));
        r3_next[8] = rpj_pkg::clamp_unit(one - 2 * (xx + yy));
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            rp4_next[k] = 64'(r3_reg[k]) * 64'(obs3_reg.point[k % 3]);
        end
    end

    always_comb begin
        rpj_pkg::s64_t acc;
        cam_next.r = r4_reg;
        cam_next.meas_u = obs4_reg.meas_u;
        cam_next.meas_v = obs4_reg.meas_v;
        for (int i = 0; i < 3; i++) begin
            acc = rp4_reg[3 * i] + rp4_reg[3 * i + 1] + rp4_reg[3 * i + 2];
            cam_next.cam[i] = rpj_pkg::sat32(rpj_pkg::rnd_quat(acc) + 64'(obs4_reg.trans[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            obs1_reg <= obs1_next;
            obs2_reg <= obs1_reg;
            qp2_reg  <= qp2_next;
            obs3_reg <= obs2_reg;
            r3_reg   <= r3_next;
            obs4_reg <= obs3_reg;
            r4_reg   <= r3_reg;
            rp4_reg  <= rp4_next;
            cam_out  <= cam_next;
        end
    end

endmodule

[hw/rtl/rpj_div.sv]
// Pipelined signed divider: quotient rounded half away from zero, saturated to 32 bits.
// One quotient bit per stage. Depends on rpj_pkg.
`timescale 1ns / 1ps

module rpj_div (
    input  logic          aclk,
    input  logic          en,
    input  rpj_pkg::s64_t num,
    input  rpj_pkg::s32_t den,
    output rpj_pkg::s32_t quo
);

    localparam int QB = rpj_pkg::QUO_BITS;

    logic [63:0]   rem_reg [QB+1];
    logic [31:0]   den_reg [QB+1];
    logic [QB-1:0] quo_reg [QB+1];
    logic          neg_reg [QB+1];
    logic          sat_reg [QB+1];

    logic [63:0]   rem_next [QB+1];
    logic [QB-1:0] quo_next [QB+1];
    rpj_pkg::s32_t quo_out;

    always_comb begin
        logic [63:0] un;
        logic [31:0] ud;
        logic [63:0] shifted;
        un = num[63] ? 64'(-num) : 64'(num);
        ud = den[31] ? (~den + 32'd1) : den;
        rem_next[0] = un + 64'(ud[31:1]);
        quo_next[0] = '0;
        for (int s = 1; s <= QB; s++) begin
            shifted = 64'(den_reg[s-1]) << (QB - s);
            if (rem_reg[s-1] >= shifted) begin
                rem_next[s] = rem_reg[s-1] - shifted;
                quo_next[s] = {quo_reg[s-1][QB-2:0], 1'b1};
            end else begin
                rem_next[s] = rem_reg[s-1];
                quo_next[s] = {quo_reg[s-1][QB-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [QB-1:0] q;
        q = quo_reg[QB];
        if (sat_reg[QB] || q[QB-1] || q[31]) begin
            quo_out = neg_reg[QB] ? rpj_pkg::S32_MIN : rpj_pkg::S32_MAX;
        end else if (neg_reg[QB]) begin
            quo_out = -$signed(q[31:0]);
        end else begin
            quo_out = $signed(q[31:0]);
        end
    end

    always_ff @(posedge aclk) begin
        logic [63:0] un0;
        logic [31:0] ud0;
        if (en) begin
            un0 = num[63] ? 64'(-num) : 64'(num);
            ud0 = den[31] ? (~den + 32'd1) : den;
            rem_reg[0] <= rem_next[0];
            quo_reg[0] <= quo_next[0];
            // A zero divisor runs the stages with an all-ones divisor, so that a zero
            // dividend yields a zero quotient; a nonzero dividend saturates below.
            den_reg[0] <= (ud0 == 32'd0) ? '1 : ud0;
            neg_reg[0] <= num[63] ^ den[31];
            // A quotient of 2^33 or more saturates; so does x/0 for nonzero x.
            sat_reg[0] <= ({1'b0, rem_next[0]} >= (65'(ud0) << QB)) && (un0 != 64'd0);
            for (int s = 1; s <= QB; s++) begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                den_reg[s] <= den_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                sat_reg[s] <= sat_reg[s-1];
            end
            quo <= quo_out;
        end
    end

endmodule

[hw/rtl/rpj_back.sv]
// Back end: residuals, point Jacobians and pose Jacobians of both rows, two register stages.
// Depends on rpj_pkg.
`timescale 1ns / 1ps

module rpj_back (
    input  logic           aclk,
    input  logic           en,
    input  rpj_pkg::cfg_t  cfg,
    input  rpj_pkg::quo_t  quo,
    input  rpj_pkg::side_t side,
    output rpj_pkg::rows_t rows
);

    typedef struct packed {
        rpj_pkg::s32_t  res_u;
        rpj_pkg::s32_t  res_v;
        rpj_pkg::vec3_t m_u;
        rpj_pkg::vec3_t m_v;
        rpj_pkg::s32_t  xyz;
        rpj_pkg::s32_t  sq_u;
        rpj_pkg::s32_t  sq_v;
        rpj_pkg::s32_t  u_rz;
        rpj_pkg::s32_t  u_tx;
        rpj_pkg::s32_t  u_tz;
        rpj_pkg::s32_t  v_rz;
        rpj_pkg::s32_t  v_ty;
        rpj_pkg::s32_t  v_tz;
        rpj_pkg::s32_t  fxz;
        rpj_pkg::s32_t  fyz;
        logic           pos;
    } mid_t;

    mid_t mid_reg, mid_next;
    rpj_pkg::rows_t rows_next;

    always_comb begin
        rpj_pkg::s64_t t;
        mid_next.res_u = rpj_pkg::sat32(64'(side.meas_u) - (64'(quo.proj_u) + 64'(cfg.center_x)));
        mid_next.res_v = rpj_pkg::sat32(64'(side.meas_v) - (64'(quo.proj_v) + 64'(cfg.center_y)));
        for (int j = 0; j < 3; j++) begin
            t = 64'(quo.xz) * 64'(side.r[6 + j]) - (64'(side.r[j]) <<< rpj_pkg::FRAC_BITS);
            mid_next.m_u[j] = rpj_pkg::sat32(rpj_pkg::rnd_quat(t));
            t = 64'(quo.yz) * 64'(side.r[6 + j]) - (64'(side.r[3 + j]) <<< rpj_pkg::FRAC_BITS);
            mid_next.m_v[j] = rpj_pkg::sat32(rpj_pkg::rnd_quat(t));
        end
        mid_next.xyz  = rpj_pkg::mulq(quo.xz, quo.yz);
        mid_next.sq_u = rpj_pkg::sat32(64'(rpj_pkg::mulq(quo.xz, quo.xz))
                                       + (64'sd1 <<< rpj_pkg::FRAC_BITS));
        mid_next.sq_v = rpj_pkg::sat32(64'(rpj_pkg::mulq(quo.yz, quo.yz))
                                       + (64'sd1 <<< rpj_pkg::FRAC_BITS));
        mid_next.u_rz = rpj_pkg::mulq(quo.yz, cfg.focal_x);
        mid_next.u_tx = rpj_pkg::neg_sat(quo.fxz);
        mid_next.u_tz = rpj_pkg::mulq(quo.xz, quo.fxz);
        mid_next.v_rz = rpj_pkg::neg_sat(rpj_pkg::mulq(quo.xz, cfg.focal_y));
        mid_next.v_ty = rpj_pkg::neg_sat(quo.fyz);
        mid_next.v_tz = rpj_pkg::mulq(quo.yz, quo.fyz);
        mid_next.fxz  = quo.fxz;
        mid_next.fyz  = quo.fyz;
        mid_next.pos  = side.pos;
    end

    always_comb begin
        rows_next.pos = mid_reg.pos;
        rows_next.row_u.residual = mid_reg.res_u;
        rows_next.row_v.residual = mid_reg.res_v;
        for (int j = 0; j < 3; j++) begin
            rows_next.row_u.dpt[j] = rpj_pkg::mulq(mid_reg.fxz, mid_reg.m_u[j]);
            rows_next.row_v.dpt[j] = rpj_pkg::mulq(mid_reg.fyz, mid_reg.m_v[j]);
        end
        rows_next.row_u.dpose[0] = rpj_pkg::mulq(mid_reg.xyz, cfg.focal_x);
        rows_next.row_u.dpose[1] = rpj_pkg::neg_sat(rpj_pkg::mulq(mid_reg.sq_u, cfg.focal_x));
        rows_next.row_u.dpose[2] = mid_reg.u_rz;
        rows_next.row_u.dpose[3] = mid_reg.u_tx;
        rows_next.row_u.dpose[4] = '0;
        rows_next.row_u.dpose[5] = mid_reg.u_tz;
        rows_next.row_v.dpose[0] = rpj_pkg::mulq(mid_reg.sq_v, cfg.focal_y);
        rows_next.row_v.dpose[1] = rpj_pkg::neg_sat(rpj_pkg::mulq(mid_reg.xyz, cfg.focal_y));
        rows_next.row_v.dpose[2] = mid_reg.v_rz;
        rows_next.row_v.dpose[3] = '0;
        rows_next.row_v.dpose[4] = mid_reg.v_ty;
        rows_next.row_v.dpose[5] = mid_reg.v_tz;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_reg <= mid_next;
            rows    <= rows_next;
        end
    end

endmodule

[hw/rtl/reprojection_error_jacobian.sv]
// Top level of the pinhole reprojection residual and SE3 Jacobian block.
// Depends on rpj_pkg, rpj_front, rpj_div and rpj_back.
//
// Usage: each request on the s_ channel carries one observation (world point, pose as
// quaternion and translation, measured pixel) packed in s_tdata. For every request the
// m_ channel delivers two rows, the u row then the v row; m_tlast marks the v row and
// m_tuser is the positive-depth flag. Intrinsics are written over the cfg_ port, which
// is always ready, and should only be changed while no request is in flight.
// The single output register that hands out the two rows of each request holds that
// request, and with it the whole pipe, until its v row is taken. The six divisions by
// depth run in pipelined dividers, one quotient bit per stage, so requests overlap
// across the whole pipe.
// The pipe advances as a whole: while a row is valid and m_tready is low, every stage
// holds its data and s_tready drops, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipe and restores default intrinsics:
// focal lengths 500.0, principal point (320.0, 240.0).
`timescale 1ns / 1ps

module reprojection_error_jacobian (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // point_x, point_y, point_z, quat_w, quat_x, quat_y, quat_z, trans_x, trans_y,
    // trans_z, meas_u, meas_v
    input  logic [383:0]                  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // residual, dpt_x, dpt_y, dpt_z, dpose_rx, dpose_ry, dpose_rz, dpose_tx,
    // dpose_ty, dpose_tz
    output logic [319:0]                  m_tdata,
    output logic                          m_tlast,
    // depth_positive
    output logic                          m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rpj_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int L = rpj_pkg::PIPE_LAT;

    logic [rpj_pkg::REG_W-1:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [L-1:0]   vld_reg;
    logic           row_reg;
    logic           adv;

    rpj_pkg::cfg_t  cfg;
    rpj_pkg::obs_t  obs;
    rpj_pkg::cam_t  cam;
    rpj_pkg::s64_t  num_pu_reg, num_pv_reg, num_xz_reg, num_yz_reg, num_fx_reg, num_fy_reg;
    rpj_pkg::s32_t  den_reg;
    rpj_pkg::side_t side_num_reg;
    rpj_pkg::side_t side_reg [rpj_pkg::DIV_LAT];
    rpj_pkg::quo_t  quo;
    rpj_pkg::rows_t rows;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg  <= rpj_pkg::FOCAL_X_RESET;
            focal_y_reg  <= rpj_pkg::FOCAL_Y_RESET;
            center_x_reg <= rpj_pkg::CENTER_X_RESET;
            center_y_reg <= rpj_pkg::CENTER_Y_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rpj_pkg::REG_FOCAL_X:  focal_x_reg  <= cfg_data[rpj_pkg::REG_W-1:0];
                rpj_pkg::REG_FOCAL_Y:  focal_y_reg  <= cfg_data[rpj_pkg::REG_W-1:0];
                rpj_pkg::REG_CENTER_X: center_x_reg <= cfg_data[rpj_pkg::REG_W-1:0];
                rpj_pkg::REG_CENTER_Y: center_y_reg <= cfg_data[rpj_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.focal_x  = $signed({1'b0, focal_x_reg});
    assign cfg.focal_y  = $signed({1'b0, focal_y_reg});
    assign cfg.center_x = $signed({1'b0, center_x_reg});
    assign cfg.center_y = $signed({1'b0, center_y_reg});

    assign obs.point  = s_tdata[95:0];
    assign obs.quat_w = s_tdata[127:96];
    assign obs.quat_x = s_tdata[159:128];
    assign obs.quat_y = s_tdata[191:160];
    assign obs.quat_z = s_tdata[223:192];
    assign obs.trans  = s_tdata[319:224];
    assign obs.meas_u = s_tdata[351:320];
    assign obs.meas_v = s_tdata[383:352];

    // The last stage holds one request until its v row is taken.
    assign adv      = !vld_reg[L-1] || (m_tready && row_reg);
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            row_reg <= 1'b0;
        end else begin
            if (adv) begin
                vld_reg <= {vld_reg[L-2:0], s_tvalid};
            end
            if (m_tvalid && m_tready) begin
                row_reg <= ~row_reg;
            end
        end
    end

    rpj_front u_front (
        .aclk    (aclk),
        .en      (adv),
        .obs     (obs),
        .cam_out (cam)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_pu_reg <= 64'(cfg.focal_x) * 64'(cam.cam[0]);
            num_pv_reg <= 64'(cfg.focal_y) * 64'(cam.cam[1]);
            num_xz_reg <= 64'(cam.cam[0]) <<< rpj_pkg::FRAC_BITS;
            num_yz_reg <= 64'(cam.cam[1]) <<< rpj_pkg::FRAC_BITS;
            num_fx_reg <= 64'(cfg.focal_x) <<< rpj_pkg::FRAC_BITS;
            num_fy_reg <= 64'(cfg.focal_y) <<< rpj_pkg::FRAC_BITS;
            den_reg    <= cam.cam[2];
            side_num_reg.r      <= cam.r;
            side_num_reg.meas_u <= cam.meas_u;
            side_num_reg.meas_v <= cam.meas_v;
            side_num_reg.pos    <= cam.cam[2] > 32'sd0;
            side_reg[0] <= side_num_reg;
            for (int k = 1; k < rpj_pkg::DIV_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    rpj_div u_div_pu (.aclk(aclk), .en(adv), .num(num_pu_reg), .den(den_reg), .quo(quo.proj_u));
    rpj_div u_div_pv (.aclk(aclk), .en(adv), .num(num_pv_reg), .den(den_reg), .quo(quo.proj_v));
    rpj_div u_div_xz (.aclk(aclk), .en(adv), .num(num_xz_reg), .den(den_reg), .quo(quo.xz));
    rpj_div u_div_yz (.aclk(aclk), .en(adv), .num(num_yz_reg), .den(den_reg), .quo(quo.yz));
    rpj_div u_div_fx (.aclk(aclk), .en(adv), .num(num_fx_reg), .den(den_reg), .quo(quo.fxz));
    rpj_div u_div_fy (.aclk(aclk), .en(adv), .num(num_fy_reg), .den(den_reg), .quo(quo.fyz));

    rpj_back u_back (
        .aclk (aclk),
        .en   (adv),
        .cfg  (cfg),
        .quo  (quo),
        .side (side_reg[rpj_pkg::DIV_LAT-1]),
        .rows (rows)
    );

    assign m_tvalid = vld_reg[L-1];
    assign m_tdata  = row_reg ? rows.row_v : rows.row_u;
    assign m_tlast  = row_reg;
    assign m_tuser  = rows.pos;

    // A held request must freeze the pipe until its v row leaves.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !(m_tready && m_tlast)) |-> !s_tready)
        else $error("pipe advanced while a request was still held");

    // Rows alternate: every taken row flips the row marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (m_tlast != $past(m_tlast)))
        else $error("row marker did not alternate");

    // With no result pending the next row to go out is always the u row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> !m_tlast)
        else $error("row marker left on v row with empty output");

    // An empty output stage never blocks the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

endmodule

[dv/rpj_checker.sv]
// Result checker of the reprojection Jacobian block: watches the observation, register
// and row channels, predicts both rows of each observation and compares them.
// Depends on rpj_pkg.
`timescale 1ns / 1ps

module rpj_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [383:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [319:0] m_tdata,
    input  logic         m_tlast,
    input  logic         m_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [rpj_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           rows_pending
);

    typedef struct {
        logic          last;
        logic [319:0]  data;
        logic          pos;
    } row_exp_t;

    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;
    localparam longint ONE_Q = 64'sd1 << rpj_pkg::QUAT_BITS;
    localparam longint ONE_F = 64'sd1 << rpj_pkg::FRAC_BITS;

    row_exp_t row_fifo[$];
    longint fx, fy, cx, cy;

    function automatic longint clip32(longint v);
        return v > MAX32 ? MAX32 : (v < MIN32 ? MIN32 : v);
    endfunction

    function automatic longint clip_unit(longint v);
        return v > ONE_Q ? ONE_Q : (v < -ONE_Q ? -ONE_Q : v);
    endfunction

    // Arithmetic shift floors, so adding the half first rounds toward plus infinity.
    function automatic longint rshift(longint v, int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint fmul(longint a, longint b);
        return clip32(rshift(a * b, rpj_pkg::FRAC_BITS));
    endfunction

    function automatic longint fdiv(longint n, longint d);
        longint un, ud, q;
        if (d == 0) return n > 0 ? MAX32 : (n < 0 ? MIN32 : 0);
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = (un + ud / 2) / ud;
        if (q > (64'sd1 << 32)) q = 64'sd1 << 32;
        return clip32(((n < 0) != (d < 0)) ? -q : q);
    endfunction

    function automatic longint point_jac(longint g, longint r, longint rhi, longint rlo);
        return fmul(g, clip32(rshift(r * rhi - rlo * ONE_F, rpj_pkg::QUAT_BITS)));
    endfunction

    task automatic predict_rows(logic [383:0] obs);
        longint f[12];
        longint q[4];
        longint rm[3][3];
        longint cam[3];
        longint jr[2][10];
        longint xx, yy, zz, xy, xzq, yzq, wx, wy, wz, xz, yz, fxz, fyz, xyz, sq;
        row_exp_t e;
        for (int i = 0; i < 12; i++) f[i] = longint'($signed(obs[32*i +: 32]));
        for (int i = 0; i < 4; i++) q[i] = clip_unit(f[3 + i]);
        xx = rshift(q[1] * q[1], rpj_pkg::QUAT_BITS); yy = rshift(q[2] * q[2], rpj_pkg::QUAT_BITS);
        zz = rshift(q[3] * q[3], rpj_pkg::QUAT_BITS); xy = rshift(q[1] * q[2], rpj_pkg::QUAT_BITS);
        xzq = rshift(q[1] * q[3], rpj_pkg::QUAT_BITS);
        yzq = rshift(q[2] * q[3], rpj_pkg::QUAT_BITS);
        wx = rshift(q[0] * q[1], rpj_pkg::QUAT_BITS); wy = rshift(q[0] * q[2], rpj_pkg::QUAT_BITS);
        wz = rshift(q[0] * q[3], rpj_pkg::QUAT_BITS);
        rm[0][0] = ONE_Q - 2 * (yy + zz); rm[0][1] = 2 * (xy - wz); rm[0][2] = 2 * (xzq + wy);
        rm[1][0] = 2 * (xy + wz); rm[1][1] = ONE_Q - 2 * (xx + zz); rm[1][2] = 2 * (yzq - wx);
        rm[2][0] = 2 * (xzq - wy); rm[2][1] = 2 * (yzq + wx); rm[2][2] = ONE_Q - 2 * (xx + yy);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) rm[i][j] = clip_unit(rm[i][j]);
        for (int i = 0; i < 3; i++)
            cam[i] = clip32(rshift(rm[i][0] * f[0] + rm[i][1] * f[1] + rm[i][2] * f[2],
                                   rpj_pkg::QUAT_BITS) + f[7 + i]);
        jr[0][0] = clip32(f[10] - (fdiv(fx * cam[0], cam[2]) + cx));
        jr[1][0] = clip32(f[11] - (fdiv(fy * cam[1], cam[2]) + cy));
        xz = fdiv(cam[0] * ONE_F, cam[2]);
        yz = fdiv(cam[1] * ONE_F, cam[2]);
        fxz = fdiv(fx * ONE_F, cam[2]);
        fyz = fdiv(fy * ONE_F, cam[2]);
        for (int j = 0; j < 3; j++) begin
            jr[0][1 + j] = point_jac(fxz, xz, rm[2][j], rm[0][j]);
            jr[1][1 + j] = point_jac(fyz, yz, rm[2][j], rm[1][j]);
        end
        xyz = fmul(xz, yz);
        sq = clip32(fmul(xz, xz) + ONE_F);
        jr[0][4] = fmul(xyz, fx);
        jr[0][5] = clip32(-fmul(sq, fx));
        jr[0][6] = fmul(yz, fx);
        jr[0][7] = clip32(-fxz);
        jr[0][8] = 0;
        jr[0][9] = fmul(xz, fxz);
        sq = clip32(fmul(yz, yz) + ONE_F);
        jr[1][4] = fmul(sq, fy);
        jr[1][5] = clip32(-fmul(xyz, fy));
        jr[1][6] = clip32(-fmul(xz, fy));
        jr[1][7] = 0;
        jr[1][8] = clip32(-fyz);
        jr[1][9] = fmul(yz, fyz);
        for (int k = 0; k < 2; k++) begin
            e.last = k[0];
            e.pos = cam[2] > 0;
            for (int j = 0; j < 10; j++) e.data[32*j +: 32] = jr[k][j][31:0];
            row_fifo = {row_fifo, e};
        end
    endtask

    string field_names[10] = '{"residual", "dpt_x", "dpt_y", "dpt_z", "dpose_rx",
                               "dpose_ry", "dpose_rz", "dpose_tx", "dpose_ty", "dpose_tz"};

    always @(posedge aclk) begin
        row_exp_t e;
        int errs;
        errs = 0;
        if (!aresetn) begin
            fx = rpj_pkg::FOCAL_X_RESET; fy = rpj_pkg::FOCAL_Y_RESET;
            cx = rpj_pkg::CENTER_X_RESET; cy = rpj_pkg::CENTER_Y_RESET;
            row_fifo.delete();
            fail_count <= 0;
            rows_pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rpj_pkg::REG_FOCAL_X:  fx = cfg_data[rpj_pkg::REG_W-1:0];
                    rpj_pkg::REG_FOCAL_Y:  fy = cfg_data[rpj_pkg::REG_W-1:0];
                    rpj_pkg::REG_CENTER_X: cx = cfg_data[rpj_pkg::REG_W-1:0];
                    rpj_pkg::REG_CENTER_Y: cy = cfg_data[rpj_pkg::REG_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (row_fifo.size() == 0) begin
                    $error("row with no observation outstanding");
                    errs = errs + 1;
                end else begin
                    e = row_fifo.pop_front();
                    if (m_tlast !== e.last) begin
                        $error("row: expected %0d actual %0d", e.last, m_tlast);
                        errs = errs + 1;
                    end
                    if (m_tuser !== e.pos) begin
                        $error("depth_positive: expected %0d actual %0d", e.pos, m_tuser);
                        errs = errs + 1;
                    end
                    for (int j = 0; j < 10; j++)
                        if (m_tdata[32*j +: 32] !== e.data[32*j +: 32]) begin
                            $error("%s: expected %0d actual %0d", field_names[j],
                                   $signed(e.data[32*j +: 32]), $signed(m_tdata[32*j +: 32]));
                            errs = errs + 1;
                        end
                end
            end
            // Requests enter after results leave in the same edge, which is harmless.
            if (s_tvalid && s_tready) predict_rows(s_tdata);
            if (errs != 0) fail_count <= fail_count + errs;
            rows_pending <= row_fifo.size();
        end
    end
endmodule

[dv/reprojection_error_jacobian_test.sv]
// Testbench top of the reprojection Jacobian block: drives observations and register
// writes with random idling and gives the verdict. Depends on rpj_pkg and rpj_checker.
`timescale 1ns / 1ps

module reprojection_error_jacobian_test;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     ONE_Q       = 1 << rpj_pkg::QUAT_BITS;
    // An index past the register list; writes to it are ignored.
    localparam logic [rpj_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [383:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [319:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [rpj_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    int           fail_count;
    int           rows_pending;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    longint       cycle_count = 0;

    always #10 aclk = ~aclk;

    reprojection_error_jacobian u_dut (.*);

    rpj_checker u_checker (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("reprojection_error_jacobian regression: fail");
            $finish;
        end
    end

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic write_reg(logic [rpj_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every row has come out, then let the pipe drain fully.
    task automatic drain_rows();
        while (rows_pending != 0) @(negedge aclk);
        repeat (rpj_pkg::PIPE_LAT + 10) @(negedge aclk);
    endtask

    task automatic send_obs(logic [383:0] obs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= obs;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_edge32();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a plausible scene: quaternion parts in [-0.5, 0.5], point mostly in front.
    function automatic logic [383:0] rand_obs();
        logic [383:0] o;
        int mode;
        mode = $urandom_range(9);
        for (int i = 0; i < 12; i++) o[32*i +: 32] = rand_edge32();
        if (mode < 7) begin
            for (int i = 0; i < 3; i++) o[32*i +: 32] = $signed($urandom_range(2000000)) - 1000000;
            for (int i = 3; i < 7; i++) o[32*i +: 32] = $signed($urandom_range(ONE_Q)) - ONE_Q / 2;
            for (int i = 7; i < 10; i++) o[32*i +: 32] = $signed($urandom_range(2000000)) - 1000000;
            o[32*9 +: 32] = $urandom_range(20000000);
            o[32*10 +: 32] = $urandom_range(50000000);
            o[32*11 +: 32] = $urandom_range(40000000);
        end else if (mode == 7) begin
            for (int i = 3; i < 7; i++) o[32*i +: 32] = $signed($urandom_range(2*ONE_Q)) - ONE_Q;
        end
        return o;
    endfunction

    function automatic logic [383:0] make_obs(int px, int py, int pz, int qw, int qx,
                                             int qy, int qz, int tx, int ty, int tz);
        return {32'd20971520, 32'd20971520, tz, ty, tx, qz, qy, qx, qw, pz, py, px};
    endfunction

    initial begin
        logic [31:0] focal_set[4] = '{32'd32768000, 32'h7FFFFFFF, 32'd0, 32'hFFFFFFFF};
        logic [383:0] obs;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: identity pose, zero and negative depth, quaternion clamp, extremes.
        send_obs(make_obs(65536, 65536, 0, ONE_Q, 0, 0, 0, 0, 0, 10 << 16));
        send_obs(make_obs(65536, -65536, 0, ONE_Q, 0, 0, 0, 0, 0, 0));
        send_obs(make_obs(0, 0, 0, ONE_Q, 0, 0, 0, 0, 0, 0));
        send_obs(make_obs(65536, 65536, -(5 << 16), ONE_Q, 0, 0, 0, 0, 0, 0));
        send_obs(make_obs(1 << 20, 1 << 18, 1 << 19, 32'h7FFFFFFF, 32'h80000000,
                          32'h7FFFFFFF, 32'h80000000, 0, 0, 0));
        send_obs(make_obs(0, 0, 0, 0, ONE_Q, 0, 0, 3 << 16, 0, 2 << 16));
        send_obs({12{32'h7FFFFFFF}});
        send_obs({12{32'h80000000}});
        send_obs({12{32'hFFFFFFFF}});
        send_obs('0);
        send_obs(make_obs(7, -3, 1, ONE_Q / 2, ONE_Q / 2, ONE_Q / 2, ONE_Q / 2, 0, 0, 1));
        for (int i = 0; i < 8; i++) send_obs(rand_obs());
        s_tvalid <= 1'b0;
        drain_rows();

        for (int phase = 0; phase < 4; phase++) begin
            write_reg(rpj_pkg::REG_FOCAL_X, focal_set[phase]);
            write_reg(rpj_pkg::REG_FOCAL_Y, focal_set[(phase + 1) % 4]);
            write_reg(rpj_pkg::REG_CENTER_X, phase == 1 ? 32'hFFFFFFFF : $urandom);
            write_reg(rpj_pkg::REG_CENTER_Y, phase == 2 ? 32'h0 : $urandom);
            write_reg(REG_UNUSED, $urandom);
            send_idle_pct = phase == 0 ? 16 : (phase == 1 ? 68 : 0);
            recv_idle_pct = phase == 0 ? 68 : (phase == 1 ? 16 : 0);
            for (int n = 0; n < 285; n++) begin
                send_obs(rand_obs());
                if (n == 140) begin
                    s_tvalid <= 1'b0;
                    while (rows_pending != 0) @(negedge aclk);
                end
            end
            s_tvalid <= 1'b0;
            drain_rows();
        end

        if (fail_count == 0) begin
            $display("reprojection_error_jacobian regression: pass");
        end else begin
            $display("reprojection_error_jacobian regression: fail");
        end
        $finish;
    end
endmodule
